[design/addressed_command_deframer_unit_defines.svh]
// Assertion macros used by the deframer frame sequencer.
`ifndef ADDRESSED_COMMAND_DEFRAMER_UNIT_DEFINES_SVH
`define ADDRESSED_COMMAND_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ACDU_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ACDU_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

[design/acdu_pkg.sv]
// Types and constants for the addressed command deframer.
package acdu_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SYNC,
		ST_ARGS,
		ST_EMIT
	} frame_state_t;

	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_SYNC_BYTE      = 2'd1;
	localparam logic [1:0] REG_BROADCAST_BYTE = 2'd2;

	localparam int MAX_RESULTS = 15;

	localparam logic [7:0] BLOCK_LOW  = 8'hF0;
	localparam logic [7:0] BLOCK_HIGH = 8'hFE;

	localparam logic [7:0] RST_DEVICE_ADDRESS = 8'h00;
	localparam logic [7:0] RST_SYNC_BYTE      = 8'hAA;
	localparam logic [7:0] RST_BROADCAST_BYTE = 8'hFF;

	// Control from the frame sequencer to the cell row and the result port.
	typedef struct packed {
		logic       shift;
		logic       valid;
		logic       last;
		logic [3:0] index;
		logic [7:0] action;
	} acdu_ctl_t;

endpackage

[design/addressed_command_deframer_unit.sv]
// Top level of the addressed command deframer: config registers, cell row, ports.
//
//  Channel  | Direction | Moves                                   | Handshake
//  s_*      | in        | rx_byte                                 | tvalid/tready
//  m_*      | out       | action_byte, arg_index, arg_value, last | tvalid/tready
//  APB p*   | in/out    | device_address, sync_byte, broadcast    | psel/penable
//
// Bytes are taken while s_tready is high. The byte that completes a frame
// starts a drain of min(ARG_COUNT, 15) results, one per cycle in which m_tready
// is high, taken from the head of the row of ARG_COUNT argument cells; s_tready
// is low for the drain. A stalled m_tready holds the current result and the row.
// arst_n clears the sequencer and restores register defaults; cells are not reset.
module addressed_command_deframer_unit #(
	parameter int ARG_COUNT = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [7:0] rx_byte
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// m_tdata: [7:0] action_byte, [11:8] arg_index, [19:12] arg_value, [23:20] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import acdu_pkg::*;

	logic [7:0] device_address_q, sync_byte_q, broadcast_byte_q;
	logic       wr_en;
	acdu_ctl_t  ctl;
	logic [7:0] chain [ARG_COUNT+1];

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= RST_DEVICE_ADDRESS;
			sync_byte_q      <= RST_SYNC_BYTE;
			broadcast_byte_q <= RST_BROADCAST_BYTE;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DEVICE_ADDRESS: device_address_q <= pwdata[7:0];
				REG_SYNC_BYTE:      sync_byte_q      <= pwdata[7:0];
				REG_BROADCAST_BYTE: broadcast_byte_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEVICE_ADDRESS: prdata = {24'd0, device_address_q};
			REG_SYNC_BYTE:      prdata = {24'd0, sync_byte_q};
			REG_BROADCAST_BYTE: prdata = {24'd0, broadcast_byte_q};
			default:            prdata = '0;
		endcase
	end

	acdu_frame_ctrl #(
		.ARG_COUNT(ARG_COUNT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.rx_byte       (s_tdata),
		.m_tready      (m_tready),
		.device_address(device_address_q),
		.sync_byte     (sync_byte_q),
		.broadcast_byte(broadcast_byte_q),
		.ctl           (ctl)
	);

	// new bytes enter at cell 0; the oldest argument sits in the last cell
	assign chain[0] = s_tdata;

	for (genvar i = 0; i < ARG_COUNT; i++) begin : g_cell
		acdu_cell u_cell (
			.clk  (clk),
			.shift(ctl.shift),
			.d    (chain[i]),
			.q    (chain[i+1])
		);
	end

	assign m_tvalid = ctl.valid;
	assign m_tlast  = ctl.last;
	assign m_tdata  = {4'd0, chain[ARG_COUNT], ctl.index, ctl.action};

endmodule

[design/acdu_cell.sv]
// One storage cell of the argument row: loads its neighbor's byte on shift.
module acdu_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

[design/acdu_frame_ctrl.sv]
// Frame sequencer: sync and address decode, argument count, result drain.
`include "addressed_command_deframer_unit_defines.svh"

module acdu_frame_ctrl #(
	parameter int ARG_COUNT = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          rx_byte,
	input  logic                m_tready,
	input  logic [7:0]          device_address,
	input  logic [7:0]          sync_byte,
	input  logic [7:0]          broadcast_byte,
	output acdu_pkg::acdu_ctl_t ctl
);
	import acdu_pkg::*;

	localparam int CNT_W = (ARG_COUNT > 1) ? $clog2(ARG_COUNT) : 1;
	localparam int EMIT  = (ARG_COUNT < MAX_RESULTS) ? ARG_COUNT : MAX_RESULTS;

	frame_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0]       idx_q, idx_d;
	logic [7:0]       action_q, action_d;
	logic             acc, is_sync, addr_hit, shift_in, shift_out, last;

	assign is_sync  = (rx_byte == sync_byte);
	assign addr_hit = (rx_byte == device_address)
		|| ((rx_byte >= BLOCK_LOW) && (rx_byte <= BLOCK_HIGH)
			&& (rx_byte[3:0] == device_address[7:4]))
		|| (rx_byte == broadcast_byte);
	assign last     = (idx_q == 4'(EMIT - 1));

	always_comb begin
		s_tready  = (state_q != ST_EMIT);
		acc       = s_tvalid && s_tready;
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		action_d  = action_q;
		shift_in  = 1'b0;
		shift_out = 1'b0;
		if (acc) begin
			if (is_sync) begin
				state_d = ST_SYNC;
			end else begin
				unique case (state_q)
					ST_SYNC: begin
						action_d = rx_byte;
						cnt_d    = '0;
						state_d  = addr_hit ? ST_ARGS : ST_IDLE;
					end
					ST_ARGS: begin
						shift_in = 1'b1;
						if (cnt_q == CNT_W'(ARG_COUNT - 1)) begin
							cnt_d   = '0;
							idx_d   = '0;
							state_d = ST_EMIT;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
		end
		// drain the oldest argument from the head cell each taken result
		if ((state_q == ST_EMIT) && m_tready) begin
			shift_out = 1'b1;
			idx_d     = idx_q + 1'b1;
			if (last) begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			action_q <= '0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			action_q <= action_d;
		end
	end

	assign ctl.shift  = shift_in || shift_out;
	assign ctl.valid  = (state_q == ST_EMIT);
	assign ctl.last   = last;
	assign ctl.index  = idx_q;
	assign ctl.action = action_q;

	`ACDU_ASSERT_SAME(a_no_input_while_draining, ctl.valid, !s_tready)
	`ACDU_ASSERT_SAME(a_shift_in_only_in_args, shift_in, state_q == ST_ARGS)
	`ACDU_ASSERT_NEXT(a_last_ends_drain, ctl.valid && m_tready && last, !ctl.valid)
	`ACDU_ASSERT_SAME(a_drain_starts_at_zero, !ctl.valid ##1 ctl.valid, idx_q == 4'd0)
	`ACDU_ASSERT_SAME(a_count_in_range, 1'b1, cnt_q <= CNT_W'(ARG_COUNT - 1))

endmodule
